### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");
`define ASSERT_PROP_NR(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");
`else
`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_PROP_NR(label, clk, prop)
`endif

`endif

### src/tss_pkg.sv
// ----------------------------------------------------------------------------
// tss_pkg
// Shared constants and types of the tone slot sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package tss_pkg;

    localparam int CPU_CLOCK_HZ = 8000000;
    localparam int TICK_MS      = 10;

    localparam int CMD_W    = 2;
    localparam int FREQ_W   = 16;
    localparam int DUR_W    = 16;
    localparam int PERIOD_W = 16;
    localparam int HIGH_W   = 15;

    // Timer clock is a quarter of the CPU clock
    localparam int DIVIDEND = CPU_CLOCK_HZ / 4;
    localparam int QUO_W    = $clog2(DIVIDEND + 1);
    localparam int CNT_W    = $clog2(QUO_W);

    localparam int IN_DATA_W    = FREQ_W + DUR_W;
    localparam int OUT_FIELDS_W = 1 + PERIOD_W + HIGH_W + 1;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK  = 2'd0,
        CMD_PLAY  = 2'd1,
        CMD_QUEUE = 2'd2
    } cmd_t;

endpackage

`default_nettype wire

### src/tone_slot_sequencer_unit.sv
// ----------------------------------------------------------------------------
// tone_slot_sequencer_unit
// Buzzer tone scheduler with one playing slot and one queued slot.
// ----------------------------------------------------------------------------
// One request is taken at a time, and the next one only once the last has
// been emitted. When the timer period is left alone a request passes from the
// exec state to the emit state. When a new nonzero frequency has to be turned
// into a period, the bit-serial divider producing one quotient bit a cycle
// runs in between, in the divide state. A finished result sits in the output
// register, so the next request is taken while it waits.
// Input: s_tuser carries the command, s_tdata the frequency and duration.
`default_nettype none
`include "assert_macros.svh"

module tone_slot_sequencer_unit (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // [15:0] freq_hz, [31:16] duration_ms
    input  wire logic [tss_pkg::IN_DATA_W-1:0]   s_tdata,
    // [1:0] cmd
    input  wire logic [tss_pkg::CMD_W-1:0]       s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [0] tone_on, [16:1] period_count, [31:17] high_count, [32] reprogrammed,
    // upper bits zero
    output logic [tss_pkg::OUT_DATA_W-1:0]       m_tdata
);
    import tss_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_EMIT
    } state_t;

    state_t             state_reg,        state_next;
    cmd_t               cmd_reg,          cmd_next;
    logic [FREQ_W-1:0]  freq_in_reg,      freq_in_next;
    logic [DUR_W-1:0]   dur_in_reg,       dur_in_next;
    logic [DUR_W-1:0]   remaining_reg,    remaining_next;
    logic [FREQ_W-1:0]  current_freq_reg, current_freq_next;
    logic [FREQ_W-1:0]  queued_freq_reg,  queued_freq_next;
    logic [DUR_W-1:0]   queued_len_reg,   queued_len_next;
    logic [PERIOD_W-1:0] period_reg,      period_next;
    logic               changed_reg,      changed_next;
    logic               m_tvalid_reg,     m_tvalid_next;
    logic               tone_on_reg,      tone_on_next;
    logic [PERIOD_W-1:0] period_out_reg,  period_out_next;
    logic [HIGH_W-1:0]  high_out_reg,     high_out_next;
    logic               reprog_out_reg,   reprog_out_next;

    logic               tone_req;
    logic [FREQ_W-1:0]  tone_freq;
    logic               div_start;
    logic               div_done;
    logic [QUO_W-1:0]   div_quo;
    logic [PERIOD_W-1:0] div_sat;

    tss_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .divisor  (tone_freq),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Clamp the period to the timer width
    assign div_sat = (|div_quo[QUO_W-1:PERIOD_W]) ? '1 : div_quo[PERIOD_W-1:0];

    always_comb begin
        state_next        = state_reg;
        cmd_next          = cmd_reg;
        freq_in_next      = freq_in_reg;
        dur_in_next       = dur_in_reg;
        remaining_next    = remaining_reg;
        current_freq_next = current_freq_reg;
        queued_freq_next  = queued_freq_reg;
        queued_len_next   = queued_len_reg;
        period_next       = period_reg;
        changed_next      = changed_reg;
        m_tvalid_next     = m_tvalid_reg && !m_tready;
        tone_on_next      = tone_on_reg;
        period_out_next   = period_out_reg;
        high_out_next     = high_out_reg;
        reprog_out_next   = reprog_out_reg;
        tone_req          = 1'b0;
        tone_freq         = '0;
        div_start         = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd_next     = cmd_t'(s_tuser);
                    freq_in_next = s_tdata[FREQ_W-1:0];
                    dur_in_next  = s_tdata[FREQ_W +: DUR_W];
                    state_next   = ST_EXEC;
                end
            end
            ST_EXEC: begin
                unique case (cmd_reg)
                    CMD_TICK: begin
                        if (remaining_reg != '0) begin
                            // Saturate at zero; the queue is looked at next tick
                            remaining_next = (remaining_reg > DUR_W'(TICK_MS)) ?
                                             remaining_reg - DUR_W'(TICK_MS) : '0;
                        end else if (queued_len_reg != '0) begin
                            tone_req        = 1'b1;
                            tone_freq       = queued_freq_reg;
                            remaining_next  = queued_len_reg;
                            queued_len_next = '0;
                        end else begin
                            tone_req = 1'b1;
                        end
                    end
                    CMD_PLAY: begin
                        tone_req        = 1'b1;
                        tone_freq       = freq_in_reg;
                        remaining_next  = dur_in_reg;
                        queued_len_next = '0;
                    end
                    CMD_QUEUE: begin
                        queued_freq_next = freq_in_reg;
                        queued_len_next  = dur_in_reg;
                    end
                    default: begin
                    end
                endcase
                changed_next = tone_req && (tone_freq != current_freq_reg);
                state_next   = ST_EMIT;
                if (changed_next) begin
                    current_freq_next = tone_freq;
                    if (tone_freq == '0) begin
                        period_next = '0;
                    end else begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    period_next = div_sat;
                    state_next  = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // Hold until the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next   = 1'b1;
                    tone_on_next    = current_freq_reg != '0;
                    period_out_next = (current_freq_reg != '0) ? period_reg : '0;
                    high_out_next   = (current_freq_reg != '0) ?
                                      period_reg[PERIOD_W-1:1] : '0;
                    reprog_out_next = changed_reg;
                    state_next      = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            cmd_reg          <= CMD_TICK;
            freq_in_reg      <= '0;
            dur_in_reg       <= '0;
            remaining_reg    <= '0;
            current_freq_reg <= '0;
            queued_freq_reg  <= '0;
            queued_len_reg   <= '0;
            period_reg       <= '0;
            changed_reg      <= 1'b0;
            m_tvalid_reg     <= 1'b0;
            tone_on_reg      <= 1'b0;
            period_out_reg   <= '0;
            high_out_reg     <= '0;
            reprog_out_reg   <= 1'b0;
        end else begin
            state_reg        <= state_next;
            cmd_reg          <= cmd_next;
            freq_in_reg      <= freq_in_next;
            dur_in_reg       <= dur_in_next;
            remaining_reg    <= remaining_next;
            current_freq_reg <= current_freq_next;
            queued_freq_reg  <= queued_freq_next;
            queued_len_reg   <= queued_len_next;
            period_reg       <= period_next;
            changed_reg      <= changed_next;
            m_tvalid_reg     <= m_tvalid_next;
            tone_on_reg      <= tone_on_next;
            period_out_reg   <= period_out_next;
            high_out_reg     <= high_out_next;
            reprog_out_reg   <= reprog_out_next;
        end
    end

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(OUT_DATA_W - OUT_FIELDS_W)'(0), reprog_out_reg, high_out_reg,
                       period_out_reg, tone_on_reg};

    `ASSERT_PROP(a_silent_no_period, aclk, aresetn, (current_freq_reg == '0) |-> (period_reg == '0))
    `ASSERT_PROP(a_div_done_in_wait, aclk, aresetn, div_done |-> (state_reg == ST_DIV))
    `ASSERT_PROP(a_busy_after_accept, aclk, aresetn, (s_tvalid && s_tready) |=> !s_tready)

endmodule

`default_nettype wire

### src/tss_div.sv
// ----------------------------------------------------------------------------
// tss_div
// Restoring divider: timer clock over tone frequency, one quotient bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module tss_div (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [tss_pkg::FREQ_W-1:0]  divisor,
    output logic                             done,
    output logic [tss_pkg::QUO_W-1:0]        quotient
);
    import tss_pkg::*;

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [FREQ_W-1:0]   rem_reg;
    logic [FREQ_W-1:0]   dvs_reg;
    logic [QUO_W-1:0]    quo_reg;

    logic [FREQ_W:0]     trial;
    logic                fits;
    logic [FREQ_W:0]     diff;

    // Shift in the next dividend bit and try a subtraction
    always_comb begin
        trial = {rem_reg, quo_reg[QUO_W-1]};
        fits  = trial >= {1'b0, dvs_reg};
        diff  = trial - {1'b0, dvs_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            dvs_reg  <= '0;
            quo_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start && !busy_reg) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(QUO_W - 1);
                rem_reg  <= '0;
                dvs_reg  <= divisor;
                quo_reg  <= QUO_W'(DIVIDEND);
            end else if (busy_reg) begin
                rem_reg <= fits ? diff[FREQ_W-1:0] : trial[FREQ_W-1:0];
                quo_reg <= {quo_reg[QUO_W-2:0], fits};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

    `ASSERT_PROP(a_start_when_free, aclk, aresetn, start |-> !busy_reg)
    `ASSERT_PROP(a_done_ends_run, aclk, aresetn, done_reg |-> (!busy_reg && $past(busy_reg)))
    `ASSERT_PROP(a_nonzero_divisor, aclk, aresetn, busy_reg |-> (dvs_reg != '0))

endmodule

`default_nettype wire

### bench/tone_slot_sequencer_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tone_slot_sequencer_unit_tb
// Self-checking bench for the tone slot sequencer. A queue of tick, play,
// queue and spare requests is streamed in with random gaps. Each accepted
// request is run through a behavioural model of the playing and queued slots,
// and the expected tone state is compared field by field with the result
// stream, which is itself back-pressured at random.
// ----------------------------------------------------------------------------
module tone_slot_sequencer_unit_tb;
    import tss_pkg::*;

    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
    localparam int MAX_IDLE      = 14;
    localparam int RANDOM_ITEMS  = 500;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 200000;

    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [FREQ_W-1:0] freq;
        logic [DUR_W-1:0]  dur;
        int                gap;
        bit                drain;
    } tone_req_t;

    typedef struct {
        logic                tone_on;
        logic [PERIOD_W-1:0] period;
        logic [HIGH_W-1:0]   high;
        logic                reprog;
    } tone_out_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [CMD_W-1:0]      s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;

    tone_req_t tone_requests[$];
    tone_out_t expected_tones[$];
    tone_req_t in_flight;
    int        requests_left;
    int        idle_count;
    int        send_mode;
    int        stall_left;
    int        stall_mode;
    int        errors;
    int        cycle_count;

    // model of the two slots and the timer
    logic [16:0]         play_left_ms;
    logic [FREQ_W-1:0]   sounding_freq;
    logic [FREQ_W-1:0]   next_freq;
    logic [DUR_W-1:0]    next_len;
    logic [PERIOD_W-1:0] timer_period;

    tone_slot_sequencer_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Burst modes: none, full range, short
    function automatic int draw_idle(input int mode);
        case (mode)
            0:       return 0;
            1:       return $urandom_range(0, MAX_IDLE);
            default: return $urandom_range(0, 3);
        endcase
    endfunction

    function automatic bit retune(input logic [FREQ_W-1:0] freq);
        int unsigned quo;
        if (freq == sounding_freq)
            return 1'b0;
        sounding_freq = freq;
        if (freq == '0) begin
            timer_period = '0;
        end else begin
            quo = DIVIDEND / freq;
            timer_period = (quo > 32'hFFFF) ? 16'hFFFF : quo[PERIOD_W-1:0];
        end
        return 1'b1;
    endfunction

    task automatic predict_tone(input tone_req_t req);
        bit        changed;
        tone_out_t want;
        changed = 1'b0;
        case (req.cmd)
            CMD_TICK: begin
                if (play_left_ms != '0) begin
                    // saturate at zero; the queued tone waits for the next tick
                    if (play_left_ms > TICK_MS)
                        play_left_ms = play_left_ms - 17'(TICK_MS);
                    else
                        play_left_ms = '0;
                end else if (next_len != '0) begin
                    changed = retune(next_freq);
                    play_left_ms = {1'b0, next_len};
                    next_len = '0;
                end else begin
                    changed = retune('0);
                end
            end
            CMD_PLAY: begin
                changed = retune(req.freq);
                play_left_ms = {1'b0, req.dur};
                next_len = '0;
            end
            CMD_QUEUE: begin
                next_freq = req.freq;
                next_len = req.dur;
            end
            default: ;
        endcase
        want.tone_on = (sounding_freq != '0);
        want.period  = want.tone_on ? timer_period : '0;
        want.high    = want.period[PERIOD_W-1:1];
        want.reprog  = changed;
        expected_tones.push_back(want);
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    function automatic void add_req(input logic [CMD_W-1:0] cmd, input logic [FREQ_W-1:0] freq,
                                    input logic [DUR_W-1:0] dur, input bit drain);
        tone_req_t req;
        if ($urandom_range(0, 39) == 0)
            send_mode = $urandom_range(0, 2);
        req.cmd   = cmd;
        req.freq  = freq;
        req.dur   = dur;
        req.gap   = draw_idle(send_mode);
        req.drain = drain;
        tone_requests.push_back(req);
    endfunction

    function automatic logic [FREQ_W-1:0] pick_freq();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 10)
            return '0;
        else if (sel < 25)
            return FREQ_W'($urandom_range(1, 40));
        else if (sel < 60)
            case ($urandom_range(0, 4))
                0:       return 16'd440;
                1:       return 16'd880;
                2:       return 16'd262;
                3:       return 16'd20;
                default: return 16'd1000;
            endcase
        else
            return FREQ_W'($urandom);
    endfunction

    function automatic logic [DUR_W-1:0] pick_dur();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 10)
            return '0;
        else if (sel < 94)
            return DUR_W'($urandom_range(1, 60));
        else
            return DUR_W'($urandom);
    endfunction

    // Request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            idle_count = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_tone(in_flight);
                requests_left--;
            end
            if (!s_tvalid || s_tready) begin
                // hold a draining request back until every result is in
                if (tone_requests.size() != 0 && idle_count >= tone_requests[0].gap &&
                    !(tone_requests[0].drain && expected_tones.size() != 0)) begin
                    in_flight = tone_requests.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {in_flight.dur, in_flight.freq};
                    s_tuser  <= in_flight.cmd;
                    idle_count = 0;
                end else begin
                    s_tvalid <= 1'b0;
                    idle_count++;
                end
            end
        end
    end

    // Result monitor
    always @(posedge aclk) begin
        tone_out_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_tones.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
                    errors++;
                end else begin
                    want = expected_tones.pop_front();
                    check_field("tone_on", want.tone_on, m_tdata[0]);
                    check_field("period_count", want.period, m_tdata[16:1]);
                    check_field("high_count", want.high, m_tdata[31:17]);
                    check_field("reprogrammed", want.reprog, m_tdata[32]);
                    check_field("padding", '0, m_tdata[OUT_DATA_W-1:33]);
                end
                if ($urandom_range(0, 29) == 0)
                    stall_mode = $urandom_range(0, 2);
                stall_left = draw_idle(stall_mode);
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        int               sel;
        logic [CMD_W-1:0] cmd;

        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = '0;
        m_tready      = 1'b0;
        errors        = 0;
        cycle_count   = 0;
        send_mode     = 1;
        stall_mode    = 1;
        play_left_ms  = '0;
        sounding_freq = '0;
        next_freq     = '0;
        next_len      = '0;
        timer_period  = '0;

        // silence while already silent
        add_req(CMD_TICK, 16'hFFFF, 16'hFFFF, 1'b0);
        add_req(CMD_PLAY, 16'h0000, 16'd30, 1'b0);
        // extremes, period overflow, same frequency
        add_req(CMD_PLAY, 16'hFFFF, 16'hFFFF, 1'b0);
        add_req(CMD_PLAY, 16'd1, 16'd5, 1'b0);
        add_req(CMD_PLAY, 16'd1, 16'd20, 1'b0);
        add_req(CMD_PLAY, 16'd31, 16'd20, 1'b0);
        // queued tone taken once the time runs out, with overshoot
        add_req(CMD_QUEUE, 16'd440, 16'd7, 1'b0);
        add_req(CMD_TICK, 16'h0000, 16'h0000, 1'b0);
        add_req(CMD_TICK, 16'h0000, 16'h0000, 1'b0);
        add_req(CMD_TICK, 16'h0000, 16'h0000, 1'b0);
        add_req(CMD_TICK, 16'h0000, 16'h0000, 1'b0);
        add_req(CMD_TICK, 16'h0000, 16'h0000, 1'b0);
        // zero length queues nothing
        add_req(CMD_QUEUE, 16'd1000, 16'd0, 1'b0);
        add_req(CMD_TICK, 16'h0000, 16'h0000, 1'b0);
        // play-now discards the queued tone
        add_req(CMD_PLAY, 16'd500, 16'd10, 1'b0);
        add_req(CMD_QUEUE, 16'd800, 16'd50, 1'b0);
        add_req(CMD_PLAY, 16'd600, 16'd10, 1'b0);
        add_req(CMD_TICK, 16'h0000, 16'h0000, 1'b0);
        add_req(CMD_TICK, 16'h0000, 16'h0000, 1'b0);
        // queued silence stops the tone
        add_req(CMD_PLAY, 16'd300, 16'd0, 1'b0);
        add_req(CMD_QUEUE, 16'd0, 16'd5, 1'b0);
        add_req(CMD_TICK, 16'h0000, 16'h0000, 1'b0);
        // spare command reports the state only
        add_req(CMD_PLAY, 16'd2, 16'd40, 1'b0);
        add_req(CMD_SPARE, 16'hFFFF, 16'hFFFF, 1'b1);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < 55)
                cmd = CMD_TICK;
            else if (sel < 75)
                cmd = CMD_PLAY;
            else if (sel < 95)
                cmd = CMD_QUEUE;
            else
                cmd = CMD_SPARE;
            if (cmd == CMD_TICK || cmd == CMD_SPARE)
                add_req(cmd, FREQ_W'($urandom), DUR_W'($urandom), (i % 97) == 50);
            else
                add_req(cmd, pick_freq(), pick_dur(), (i % 97) == 50);
        end
        requests_left = tone_requests.size();

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        while (requests_left != 0 || expected_tones.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### sim.f
+incdir+src
src/tss_pkg.sv
src/tss_div.sv
src/tone_slot_sequencer_unit.sv
bench/tone_slot_sequencer_unit_tb.sv
